// ----- hw/rtl/fig_pkg.sv -----
//==============================================================================
// fig_pkg - shared types and constants
// Sizes, action codes and controller/datapath command and status structs.
//==============================================================================
package fig_pkg;

    localparam int NUM_SETS_DEF = 7;

    localparam logic [1:0] ACT_TUNE = 2'd0;
    localparam logic [1:0] ACT_BP   = 2'd1;
    localparam logic [1:0] ACT_RULE = 2'd2;

    localparam logic [2:0] CFG_ERR_RECIP  = 3'd0;
    localparam logic [2:0] CFG_RATE_RECIP = 3'd1;
    localparam logic [2:0] CFG_GAIN_STEP  = 3'd2;
    localparam logic [2:0] CFG_GAIN_MAX   = 3'd3;
    localparam logic [2:0] CFG_GAIN_MIN   = 3'd4;
    localparam logic [2:0] CFG_GAIN_START = 3'd5;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_SCALE  = 4'd1;  // scale error and rate
    localparam logic [3:0] OP_MEMB   = 4'd2;  // membership of current set
    localparam logic [3:0] OP_DIVST  = 4'd3;  // unused; OP_MEMB starts the membership divide
    localparam logic [3:0] OP_DIVSTP = 4'd4;  // one divider step
    localparam logic [3:0] OP_MEMEND = 4'd5;  // finish membership, record
    localparam logic [3:0] OP_WT     = 4'd6;  // weight of one rule pair
    localparam logic [3:0] OP_ACC    = 4'd7;  // accumulate pair
    localparam logic [3:0] OP_AVGST  = 4'd8;  // start average divide
    localparam logic [3:0] OP_AVGEND = 4'd9;  // finish average
    localparam logic [3:0] OP_CHG    = 4'd10; // change and gain update

    typedef struct packed {
        logic [3:0] op;
        logic       sel_rate;   // fuzzify rate (1) or error (0)
        logic [1:0] pair;       // rule pair m*2+n
    } fig_cmd_t;

    typedef struct packed {
        logic div_done;
    } fig_sts_t;

endpackage

// ----- hw/rtl/fig_ram.sv -----
//==============================================================================
// fig_ram - generic single-port-write RAM
// One write port, one registered read port.
//==============================================================================
module fig_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 21
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/fig_ctrl.sv -----
//==============================================================================
// fig_ctrl - tune sequencer
// Steps the datapath through scaling, fuzzification, weighting and update.
//==============================================================================
module fig_ctrl
    import fig_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  fig_sts_t sts,
    output fig_cmd_t cmd,
    output logic [$clog2(NUM_SETS)-1:0] set_idx,
    output logic [1:0] corner,
    output logic     busy,
    output logic     done
);
    localparam int SW = $clog2(NUM_SETS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCALE = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_RDC   = 4'd4;
    localparam logic [3:0] S_LAT   = 4'd5;
    localparam logic [3:0] S_MEMB  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_MEND  = 4'd8;
    localparam logic [3:0] S_RRD   = 4'd9;
    localparam logic [3:0] S_WT    = 4'd10;
    localparam logic [3:0] S_ACC   = 4'd11;
    localparam logic [3:0] S_AVG   = 4'd12;
    localparam logic [3:0] S_ADIV  = 4'd13;
    localparam logic [3:0] S_AEND  = 4'd14;
    localparam logic [3:0] S_CHG   = 4'd15;

    logic [3:0]    state_reg, state_next;
    logic [SW-1:0] set_reg, set_next;
    logic          rate_reg, rate_next;
    logic [1:0]    pair_reg, pair_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            set_reg   <= '0;
            rate_reg  <= 1'b0;
            pair_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            set_reg   <= set_next;
            rate_reg  <= rate_next;
            pair_reg  <= pair_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        set_next   = set_reg;
        rate_next  = rate_reg;
        pair_next  = pair_reg;
        cmd.op       = OP_NONE;
        cmd.sel_rate = rate_reg;
        cmd.pair     = pair_reg;
        corner    = 2'd0;
        done      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCALE;
                    set_next   = '0;
                    rate_next  = 1'b0;
                    pair_next  = '0;
                end
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                corner = 2'd0;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                corner = 2'd1;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                corner = 2'd2;
                state_next = S_LAT;
            end
            S_LAT:
            begin
                corner = 2'd3;   // capture third read
                state_next = S_MEMB;
            end
            S_MEMB:
            begin
                cmd.op     = OP_MEMB;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIVSTP;
                if (sts.div_done)
                begin
                    state_next = S_MEND;
                end
            end
            S_MEND:
            begin
                cmd.op = OP_MEMEND;
                if (set_reg == SW'(NUM_SETS - 1))
                begin
                    set_next = '0;
                    if (rate_reg)
                    begin
                        state_next = S_RRD;
                    end
                    else
                    begin
                        rate_next  = 1'b1;
                        state_next = S_RDA;
                    end
                end
                else
                begin
                    set_next   = set_reg + 1'b1;
                    state_next = S_RDA;
                end
            end
            S_RRD:
            begin
                cmd.op     = OP_WT;
                state_next = S_WT;
            end
            S_WT:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                pair_next = pair_reg + 1'b1;
                state_next = (pair_reg == 2'd3) ? S_AVG : S_RRD;
            end
            S_AVG:
            begin
                cmd.op     = OP_AVGST;
                state_next = S_ADIV;
            end
            S_ADIV:
            begin
                cmd.op = OP_DIVSTP;
                if (sts.div_done)
                begin
                    state_next = S_AEND;
                end
            end
            S_AEND:
            begin
                cmd.op     = OP_AVGEND;
                state_next = S_CHG;
            end
            S_CHG:
            begin
                cmd.op     = OP_CHG;
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign set_idx = set_reg;
    assign busy    = (state_reg != S_IDLE);
endmodule

// ----- hw/rtl/fig_dp.sv -----
//==============================================================================
// fig_dp - tuner datapath
// Scaling, membership, shared restoring divider, weighting and gain update.
//==============================================================================
module fig_dp
    import fig_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  fig_cmd_t    cmd,
    output fig_sts_t    sts,
    input  logic [1:0]  corner,
    input  logic [$clog2(NUM_SETS)-1:0] set_idx,
    input  logic [15:0] bp_rdata,
    input  logic [15:0] rule_rdata,
    output logic [$clog2(NUM_SETS*NUM_SETS)-1:0] rule_raddr,
    input  logic        load_in,
    input  logic signed [31:0] error,
    input  logic signed [31:0] error_rate,
    input  logic [31:0] err_recip,
    input  logic [31:0] rate_recip,
    input  logic signed [31:0] gain_step,
    input  logic signed [31:0] gain_max,
    input  logic signed [31:0] gain_min,
    input  logic        gain_load,
    input  logic signed [31:0] gain_start,
    output logic signed [31:0] gain,
    output logic signed [31:0] gain_change,
    output logic        too_small
);
    localparam int SW = $clog2(NUM_SETS);
    localparam int RW = $clog2(NUM_SETS * NUM_SETS);
    localparam logic signed [26:0] BP_SCALE = 27'sd1000;
    localparam int DVW = 75;   // divider width

    logic signed [31:0] err_in_reg, rate_in_reg;
    logic signed [48:0] e_reg, de_reg;       // scaled values, signed Q32.16
    logic signed [48:0] a_reg, b_reg, c_reg;
    logic signed [17:0] mu_e_reg [2], mu_de_reg [2];
    logic [SW-1:0]      ie_reg [2], ide_reg [2];
    logic [1:0]         cnt_reg;
    logic               mu_one_reg;
    logic signed [65:0] num_acc_reg;
    logic [34:0]        den_acc_reg;
    logic [33:0]        w_reg;
    logic               neg_reg;
    logic [DVW-1:0]     quo_reg, rem_reg, dvs_reg;
    logic [6:0]         dcnt_reg;
    logic signed [31:0] gain_reg, chg_reg;
    logic               small_reg;
    logic               wsum_small_reg;
    logic signed [33:0] avg_reg;

    // scale: floor of product / 2^16 (arithmetic shift)
    logic signed [64:0] pe, pde;
    assign pe  = err_in_reg * $signed({1'b0, err_recip});
    assign pde = rate_in_reg * $signed({1'b0, rate_recip});

    logic signed [48:0] x_cur, bp_ext;
    assign x_cur  = cmd.sel_rate ? de_reg : e_reg;
    assign bp_ext = 49'(BP_SCALE * 27'($signed(bp_rdata))) <<< 16;

    // membership setup
    logic signed [48:0] xc, num_m, den_m;
    always_comb
    begin
        if (x_cur < a_reg)
            xc = a_reg;
        else if (x_cur > c_reg)
            xc = c_reg;
        else
            xc = x_cur;
        if (xc < b_reg)
        begin
            if (a_reg == b_reg) begin num_m = c_reg - xc; den_m = c_reg - b_reg; end
            else                begin num_m = xc - a_reg; den_m = b_reg - a_reg; end
        end
        else
        begin
            if (b_reg == c_reg) begin num_m = xc - a_reg; den_m = b_reg - a_reg; end
            else                begin num_m = c_reg - xc; den_m = c_reg - b_reg; end
        end
    end

    logic [49:0] num_abs, den_abs;
    assign num_abs = num_m[48] ? 50'(-num_m) : 50'(num_m);
    assign den_abs = den_m[48] ? 50'(-den_m) : 50'(den_m);

    // restoring divider step
    logic [DVW:0]   trial;
    logic [DVW-1:0] rem_sh;
    assign rem_sh = {rem_reg[DVW-2:0], quo_reg[DVW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};

    // membership result from quotient
    logic signed [17:0] mu_val;
    always_comb
    begin
        if (mu_one_reg)
            mu_val = 18'sd65536;
        else if (neg_reg)
            mu_val = 18'sd0;
        else if (quo_reg > DVW'(65536))
            mu_val = 18'sd65536;
        else
            mu_val = 18'(quo_reg);
    end

    // weights for current pair
    logic [0:0] pm, pn;
    assign pm = cmd.pair[1];
    assign pn = cmd.pair[0];
    logic [SW-1:0] ie_sel, ide_sel;
    assign ie_sel  = ie_reg[pm];
    assign ide_sel = ide_reg[pn];
    assign rule_raddr = RW'(ie_sel * NUM_SETS + ide_sel);

    logic signed [65:0] avg_prod;
    assign avg_prod = avg_reg * gain_step;
    logic signed [49:0] chg_fl;
    assign chg_fl = 50'(avg_prod >>> 16);
    logic signed [31:0] chg_sat;
    assign chg_sat = (chg_fl > 50'sd2147483647) ? 32'sh7fffffff :
                     (chg_fl < -50'sd2147483648) ? 32'sh80000000 : 32'(chg_fl);
    logic signed [32:0] gsum;
    assign gsum = 33'(gain_reg) + 33'(chg_sat);

    logic [65:0] num_mag;
    assign num_mag = num_acc_reg[65] ? 66'(-num_acc_reg) : 66'(num_acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= '0;
            chg_reg   <= '0;
        end
        else if (gain_load)
        begin
            gain_reg <= gain_start;
        end
        else if (cmd.op == OP_CHG)
        begin
            chg_reg   <= chg_sat;
            if (gsum >= 33'(gain_max))
                gain_reg <= gain_max;
            else if (gsum < 33'(gain_min))
                gain_reg <= gain_min;
            else
                gain_reg <= 32'(gsum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            err_in_reg  <= error;
            rate_in_reg <= error_rate;
            cnt_reg     <= '0;
        end
        // breakpoint capture: data arrives in the cycle after the read
        case (corner)
            2'd1: a_reg <= bp_ext;
            2'd2: b_reg <= bp_ext;
            2'd3: c_reg <= bp_ext;
            default: ;
        endcase
        case (cmd.op)
            OP_SCALE:
            begin
                e_reg   <= 49'(pe >>> 16);
                de_reg  <= 49'(pde >>> 16);
                cnt_reg <= '0;
                ie_reg[0] <= '0; ie_reg[1] <= '0;
                ide_reg[0] <= '0; ide_reg[1] <= '0;
                num_acc_reg <= '0;
                den_acc_reg <= '0;
            end
            OP_MEMB:
            begin
                mu_one_reg <= (den_m == '0);
                neg_reg    <= num_m[48] ^ den_m[48];
                quo_reg    <= DVW'(num_abs) << 16;
                rem_reg    <= '0;
                dvs_reg    <= DVW'(den_abs);
                dcnt_reg   <= 7'd0;
            end
            OP_DIVSTP:
            begin
                if (!trial[DVW])
                begin
                    rem_reg <= trial[DVW-1:0];
                    quo_reg <= {quo_reg[DVW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[DVW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            OP_MEMEND:
            begin
                // set 0 preloads both slots: a missing index falls back to
                // set 0 with its own membership
                if (set_idx == '0)
                begin
                    if (cmd.sel_rate)
                    begin
                        mu_de_reg[0] <= mu_val; mu_de_reg[1] <= mu_val;
                        ide_reg[0] <= '0; ide_reg[1] <= '0;
                    end
                    else
                    begin
                        mu_e_reg[0] <= mu_val; mu_e_reg[1] <= mu_val;
                        ie_reg[0] <= '0; ie_reg[1] <= '0;
                    end
                    cnt_reg <= (mu_val != 0) ? 2'd1 : 2'd0;
                end
                else if (mu_val != 0 && !cnt_reg[1])
                begin
                    if (cmd.sel_rate)
                    begin
                        mu_de_reg[cnt_reg[0]] <= mu_val;
                        ide_reg[cnt_reg[0]]   <= set_idx;
                    end
                    else
                    begin
                        mu_e_reg[cnt_reg[0]] <= mu_val;
                        ie_reg[cnt_reg[0]]   <= set_idx;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            OP_WT:
            begin
                w_reg <= 34'(mu_e_reg[pm] * mu_de_reg[pn]);
            end
            OP_ACC:
            begin
                num_acc_reg <= num_acc_reg + 66'($signed({1'b0, w_reg}) * $signed(rule_rdata));
                den_acc_reg <= den_acc_reg + 35'(w_reg);
            end
            OP_AVGST:
            begin
                wsum_small_reg <= (den_acc_reg <= 35'h100000000);
                neg_reg  <= num_acc_reg[65];
                mu_one_reg <= 1'b0;
                quo_reg  <= DVW'(num_mag) << 8;
                rem_reg  <= '0;
                dvs_reg  <= DVW'(den_acc_reg);
                dcnt_reg <= 7'd0;
            end
            OP_AVGEND:
            begin
                if (wsum_small_reg)
                    avg_reg <= '0;
                else
                    avg_reg <= neg_reg ? -34'(quo_reg) : 34'(quo_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            small_reg <= 1'b0;
        else if (cmd.op == OP_CHG)
            small_reg <= wsum_small_reg;
    end

    assign sts.div_done = (dcnt_reg == 7'(DVW - 1));
    assign gain        = gain_reg;
    assign gain_change = chg_reg;
    assign too_small   = small_reg;
endmodule

// ----- hw/rtl/fuzzy_integral_gain_tuner.sv -----
//==============================================================================
// fuzzy_integral_gain_tuner - fuzzy self-tuning integral gain
// Fuzzifies scaled error and rate, averages a 2x2 rule patch, updates gain.
//==============================================================================
//  channel | dir | handshake        | payload
//  s_axis  | in  | tvalid/tready    | tdata: error, error_rate, index, value; tuser: action
//  m_axis  | out | tvalid/tready    | tdata: gain, gain_change, weights_too_small
//  cfg     | in  | cfg_valid/ready  | cfg_index, cfg_data
// Each tune item runs the 75-step shared divider once per set for error and for rate,
// and once more for the average.
// Reset clears control and zeroes the gain; a CFG_GAIN_START write loads gain_start.
// s_axis stalls while a tune item runs or its result waits in the output register.
//==============================================================================
module fuzzy_integral_gain_tuner
    import fig_pkg::*;
#(
    parameter int NUM_SETS = NUM_SETS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,   // error, error_rate, table_index, table_value
    input  logic [1:0]   s_axis_tuser,   // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,   // gain, gain_change, weights_too_small
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam int SW = $clog2(NUM_SETS);
    localparam int BD = 3 * NUM_SETS;
    localparam int RD = NUM_SETS * NUM_SETS;
    localparam int BW = $clog2(BD);
    localparam int RW = $clog2(RD);

    logic [31:0] err_recip_reg, rate_recip_reg, step_reg, max_reg, min_reg, start_reg;
    logic        out_valid_reg;

    logic [1:0]  action;
    logic [5:0]  tindex;
    logic [15:0] tvalue;
    assign action = s_axis_tuser;
    assign tindex = s_axis_tdata[69:64];
    assign tvalue = s_axis_tdata[85:70];

    logic busy, done, acc;
    fig_cmd_t cmd;
    fig_sts_t sts;
    logic [SW-1:0] set_idx;
    logic [1:0] corner;

    assign s_axis_tready = !busy && !out_valid_reg;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_recip_reg  <= 32'h10000;
            rate_recip_reg <= 32'h10000;
            step_reg       <= 32'h10000;
            max_reg        <= 32'h7fffffff;
            min_reg        <= '0;
            start_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ERR_RECIP:  err_recip_reg  <= cfg_data;
                CFG_RATE_RECIP: rate_recip_reg <= cfg_data;
                CFG_GAIN_STEP:  step_reg       <= cfg_data;
                CFG_GAIN_MAX:   max_reg        <= cfg_data;
                CFG_GAIN_MIN:   min_reg        <= cfg_data;
                CFG_GAIN_START: start_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // breakpoint and rule stores
    logic bp_we, rule_we;
    logic [15:0] bp_rdata, rule_rdata;
    logic [BW-1:0] bp_raddr;
    logic [RW-1:0] rule_raddr;
    assign bp_we   = acc && action == ACT_BP && {1'b0, tindex} < 7'(BD);
    assign rule_we = acc && action == ACT_RULE && {1'b0, tindex} < 7'(RD);
    assign bp_raddr = BW'(set_idx * 3 + corner);

    fig_ram #(.WIDTH(16), .DEPTH(BD)) u_bp (
        .clk(clk), .we(bp_we), .waddr(BW'(tindex)), .wdata(tvalue),
        .raddr(bp_raddr), .rdata(bp_rdata));
    fig_ram #(.WIDTH(16), .DEPTH(RD)) u_rule (
        .clk(clk), .we(rule_we), .waddr(RW'(tindex)), .wdata(tvalue),
        .raddr(rule_raddr), .rdata(rule_rdata));

    fig_ctrl #(.NUM_SETS(NUM_SETS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(acc && action == ACT_TUNE), .sts(sts),
        .cmd(cmd), .set_idx(set_idx), .corner(corner), .busy(busy), .done(done));

    logic signed [31:0] gain, gchg;
    logic too_small;
    fig_dp #(.NUM_SETS(NUM_SETS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .corner(corner),
        .set_idx(set_idx), .bp_rdata(bp_rdata), .rule_rdata(rule_rdata),
        .rule_raddr(rule_raddr), .load_in(acc),
        .error(s_axis_tdata[31:0]), .error_rate(s_axis_tdata[63:32]),
        .err_recip(err_recip_reg), .rate_recip(rate_recip_reg),
        .gain_step(step_reg), .gain_max(max_reg), .gain_min(min_reg),
        .gain_load(cfg_valid && cfg_index == CFG_GAIN_START), .gain_start(cfg_data),
        .gain(gain), .gain_change(gchg), .too_small(too_small));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, too_small, gchg, gain};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready) else $error("accept while busy");
    a_done_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> m_axis_tvalid) else $error("result lost");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
`endif
endmodule
